// ===== rtl/core/accel_tilt_orientation_unit_defines.svh =====
// Assertion macros shared by the accelerometer tilt and orientation unit.
// Depends on nothing; included by the top level.
`ifndef ACCEL_TILT_ORIENTATION_UNIT_DEFINES_SVH
`define ACCEL_TILT_ORIENTATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ato assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ATO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ato assertion failed");

`endif

// ===== rtl/core/ato_pkg.sv =====
// Types, constants and tables of the accelerometer tilt and orientation unit.
// Depends on nothing; used by every other file of the unit but the defines header.
package ato_pkg;

  localparam int SCALE_SHIFT       = 15;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int RAW_W             = 16;
  localparam int MG_W              = 14;
  localparam int FR_W              = 14;
  localparam int PER_W             = 16;
  localparam int SQ_W              = 27;
  localparam int RAD_W             = 44;
  localparam int ROOT_W            = 22;
  localparam int ROOT_STEPS        = RAD_W / 2;
  localparam int VEC_W             = 26;
  localparam int DEG_W             = 11;
  localparam int STEP_W            = 5;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FULL_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD     = 2'd1;

  localparam logic [FR_W-1:0]  FULL_RANGE_RESET = 14'd2000;
  localparam logic [PER_W-1:0] PERIOD_RESET     = 16'd125;

  localparam logic [1:0] ORIENT_UP    = 2'd0;
  localparam logic [1:0] ORIENT_DOWN  = 2'd1;
  localparam logic [1:0] ORIENT_LEFT  = 2'd2;
  localparam logic [1:0] ORIENT_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE,
    OP_SQUARE,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_CORD_INIT,
    OP_CORD_STEP,
    OP_CORD_STORE,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SQUARE,
    ST_ROOT_INIT,
    ST_ROOT_STEP,
    ST_CORD_INIT,
    ST_CORD_STEP,
    ST_CORD_STORE,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    dp_op_t            op;
    logic [1:0]        sel;
    logic [STEP_W-1:0] step;
    logic              last;
  } ato_cmd_t;

  typedef struct packed {
    logic out_hold;
  } ato_status_t;

  // Entry i is atan(2^-i) in degrees times 65536, rounded to nearest.
  function automatic logic [21:0] atan_tab(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] led_code(input logic [1:0] orient);
    logic [3:0] v;
    case (orient)
      ORIENT_UP:    v = 4'b0100;
      ORIENT_DOWN:  v = 4'b0010;
      ORIENT_LEFT:  v = 4'b0001;
      default:      v = 4'b1000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ato_in_if.sv =====
// Input channel of the tilt unit: one raw three-axis sample and a tick flag.
// Depends on ato_pkg.
interface ato_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ato_pkg::RAW_W-1:0]   raw_x;
  logic signed [ato_pkg::RAW_W-1:0]   raw_y;
  logic signed [ato_pkg::RAW_W-1:0]   raw_z;
  logic                               tick;

  modport source (output valid, raw_x, raw_y, raw_z, tick, input ready);
  modport sink (input valid, raw_x, raw_y, raw_z, tick, output ready);
endinterface

// ===== rtl/core/ato_out_if.sv =====
// Result channel of the tilt unit: scaled axes, angles and orientation.
// Depends on ato_pkg.
interface ato_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ato_pkg::MG_W-1:0]  x_mg;
  logic signed [ato_pkg::MG_W-1:0]  y_mg;
  logic signed [ato_pkg::MG_W-1:0]  z_mg;
  logic signed [8:0]                tilt_2d;
  logic signed [7:0]                angle_x;
  logic signed [7:0]                angle_y;
  logic [7:0]                       angle_z;
  logic [1:0]                       orientation;
  logic [3:0]                       led_onehot;
  logic                             update;

  modport source (output valid, x_mg, y_mg, z_mg, tilt_2d, angle_x, angle_y, angle_z,
                  orientation, led_onehot, update, input ready);
  modport sink (input valid, x_mg, y_mg, z_mg, tilt_2d, angle_x, angle_y, angle_z,
                orientation, led_onehot, update, output ready);
endinterface

// ===== rtl/core/ato_cfg_if.sv =====
// Configuration write channel of the tilt unit: register index and data.
// Depends on ato_pkg.
interface ato_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ato_pkg::CFG_IDX_W-1:0]      index;
  logic [ato_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/accel_tilt_orientation_unit.sv =====
// Top level of the accelerometer tilt and orientation unit.
// Depends on ato_pkg, the channel interfaces, ato_ctrl, ato_datapath and the defines header.
// The unit takes one sample at a time and returns one result per sample; it takes
// no new sample until the last has been through the shared datapath: three scaling
// multiplies, three squarings, three square roots of one bit per cycle and four
// CORDIC angle runs of 16 iterations plus load and rounding. The result sits
// in an output register, so the next sample is accepted while it waits to be taken.
`include "accel_tilt_orientation_unit_defines.svh"

module accel_tilt_orientation_unit (
  input  logic       clk,
  input  logic       rst_n,
  ato_in_if.sink     in_ch,
  ato_cfg_if.sink    cfg_ch,
  ato_out_if.source  out_ch
);

  ato_pkg::ato_cmd_t    cmd;
  ato_pkg::ato_status_t status;
  logic                 in_ready;

  assign in_ch.ready = in_ready;

  ato_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ato_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .status (status),
    .raw_x  (in_ch.raw_x),
    .raw_y  (in_ch.raw_y),
    .raw_z  (in_ch.raw_z),
    .tick   (in_ch.tick),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  `ATO_ASSERT_NEXT(a_accept_starts_scale, clk, rst_n, in_ch.valid && in_ready, cmd.op == ato_pkg::OP_SCALE)
  `ATO_ASSERT_NOW(a_finish_needs_slot, clk, rst_n, cmd.op == ato_pkg::OP_FINISH, !status.out_hold)
  `ATO_ASSERT_NOW(a_result_from_finish, clk, rst_n, $rose(out_ch.valid), $past(cmd.op) == ato_pkg::OP_FINISH)

endmodule

// ===== rtl/core/ato_ctrl.sv =====
// Sequencer of the tilt unit: steps the datapath through scaling, roots and CORDIC.
// Depends on ato_pkg.
module ato_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ato_pkg::ato_status_t  status,
  output ato_pkg::ato_cmd_t     cmd
);

  ato_pkg::ctl_state_t state_r, state_nxt;
  logic [1:0]                  sel_r, sel_nxt;
  logic [ato_pkg::STEP_W-1:0]  step_r, step_nxt;

  localparam logic [ato_pkg::STEP_W-1:0] ROOT_LAST =
    ato_pkg::STEP_W'(ato_pkg::ROOT_STEPS - 1);
  localparam logic [ato_pkg::STEP_W-1:0] CORD_LAST =
    ato_pkg::STEP_W'(ato_pkg::CORDIC_ITERATIONS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ato_pkg::ST_IDLE;
      sel_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    step_nxt  = step_r;
    case (state_r)
      ato_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ato_pkg::ST_SCALE;
          sel_nxt   = '0;
        end
      end
      ato_pkg::ST_SCALE: begin
        if (sel_r == 2'd2) begin
          state_nxt = ato_pkg::ST_SQUARE;
          sel_nxt   = '0;
        end else begin
          sel_nxt = sel_r + 2'd1;
        end
      end
      ato_pkg::ST_SQUARE: begin
        if (sel_r == 2'd2) begin
          state_nxt = ato_pkg::ST_ROOT_INIT;
          sel_nxt   = '0;
        end else begin
          sel_nxt = sel_r + 2'd1;
        end
      end
      ato_pkg::ST_ROOT_INIT: begin
        state_nxt = ato_pkg::ST_ROOT_STEP;
        step_nxt  = '0;
      end
      ato_pkg::ST_ROOT_STEP: begin
        if (step_r == ROOT_LAST) begin
          if (sel_r == 2'd2) begin
            state_nxt = ato_pkg::ST_CORD_INIT;
            sel_nxt   = '0;
          end else begin
            state_nxt = ato_pkg::ST_ROOT_INIT;
            sel_nxt   = sel_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ato_pkg::ST_CORD_INIT: begin
        state_nxt = ato_pkg::ST_CORD_STEP;
        step_nxt  = '0;
      end
      ato_pkg::ST_CORD_STEP: begin
        if (step_r == CORD_LAST) begin
          state_nxt = ato_pkg::ST_CORD_STORE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ato_pkg::ST_CORD_STORE: begin
        if (sel_r == 2'd3) begin
          state_nxt = ato_pkg::ST_FINISH;
        end else begin
          state_nxt = ato_pkg::ST_CORD_INIT;
          sel_nxt   = sel_r + 2'd1;
        end
      end
      ato_pkg::ST_FINISH: begin
        if (!status.out_hold) begin
          state_nxt = ato_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ato_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.op    = ato_pkg::OP_NONE;
    cmd.sel   = sel_r;
    cmd.step  = step_r;
    cmd.last  = 1'b0;
    case (state_r)
      ato_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = ato_pkg::OP_LOAD;
        end
      end
      ato_pkg::ST_SCALE:      cmd.op = ato_pkg::OP_SCALE;
      ato_pkg::ST_SQUARE:     cmd.op = ato_pkg::OP_SQUARE;
      ato_pkg::ST_ROOT_INIT:  cmd.op = ato_pkg::OP_ROOT_INIT;
      ato_pkg::ST_ROOT_STEP: begin
        cmd.op   = ato_pkg::OP_ROOT_STEP;
        cmd.last = (step_r == ROOT_LAST);
      end
      ato_pkg::ST_CORD_INIT:  cmd.op = ato_pkg::OP_CORD_INIT;
      ato_pkg::ST_CORD_STEP:  cmd.op = ato_pkg::OP_CORD_STEP;
      ato_pkg::ST_CORD_STORE: cmd.op = ato_pkg::OP_CORD_STORE;
      ato_pkg::ST_FINISH: begin
        if (!status.out_hold) begin
          cmd.op = ato_pkg::OP_FINISH;
        end
      end
      default: cmd.op = ato_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/ato_datapath.sv =====
// Datapath of the tilt unit: scaling, square roots, shared CORDIC and result register.
// Depends on ato_pkg, ato_out_if and ato_cfg_if.
module ato_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ato_pkg::ato_cmd_t                 cmd,
  output ato_pkg::ato_status_t              status,
  input  logic signed [ato_pkg::RAW_W-1:0]  raw_x,
  input  logic signed [ato_pkg::RAW_W-1:0]  raw_y,
  input  logic signed [ato_pkg::RAW_W-1:0]  raw_z,
  input  logic                              tick,
  ato_cfg_if.sink                           cfg_ch,
  ato_out_if.source                         out_ch
);

  localparam int PROD_W = ato_pkg::RAW_W + ato_pkg::FR_W + 1;
  localparam int REM_W  = ato_pkg::ROOT_W + 2;
  localparam int TRY_W  = REM_W + 2;
  localparam int VW     = ato_pkg::VEC_W;
  localparam int DW     = ato_pkg::DEG_W;

  logic [ato_pkg::FR_W-1:0]           fr_r;
  logic [ato_pkg::PER_W-1:0]          per_r;
  logic signed [ato_pkg::RAW_W-1:0]   rx_r, ry_r, rz_r;
  logic                               tick_r;
  logic signed [ato_pkg::MG_W-1:0]    x_r, y_r, z_r;
  logic [ato_pkg::SQ_W-1:0]           sqx_r, sqy_r, sqz_r;
  logic [ato_pkg::RAD_W-1:0]          rad_r;
  logic [REM_W-1:0]                   rem_r;
  logic [ato_pkg::ROOT_W-1:0]         rt_r, ryz_r, rxz_r, rxy_r;
  logic signed [VW-1:0]               num_r, den_r, acc_r;
  logic                               zero_r;
  logic signed [DW-1:0]               a2_r, ax_r, ay_r, az_r;
  logic [ato_pkg::PER_W-1:0]          cnt_r;
  logic [1:0]                         orient_r;
  logic                               ov_r;

  logic signed [ato_pkg::RAW_W-1:0]   raw_sel;
  logic signed [PROD_W-1:0]           prod, prod_sh;
  logic signed [ato_pkg::MG_W-1:0]    mg_sat, mg_sel;
  logic signed [2*ato_pkg::MG_W-1:0]  sq_full;
  logic [ato_pkg::SQ_W:0]             sq_sum;
  logic [TRY_W-1:0]                   rem_sh, trial;
  logic                               ge;
  logic [ato_pkg::ROOT_W-1:0]         rt_nxt;
  logic signed [VW-1:0]               vn, vd, n0, d0, a0;
  logic signed [VW-1:0]               nsh, dsh, tab;
  logic [VW-1:0]                      mag;
  logic [VW-1:0]                      rnd;
  logic signed [DW-1:0]               deg, lo, hi, deg_c;
  logic [ato_pkg::PER_W-1:0]          cnt1;
  logic [ato_pkg::MG_W-1:0]           abs_x, abs_y, abs_z;
  logic [1:0]                         orient_nxt;
  logic                               upd;

  assign cfg_ch.ready   = 1'b1;
  assign status.out_hold = ov_r && !out_ch.ready;

  always_comb begin
    case (cmd.sel)
      2'd0:    raw_sel = rx_r;
      2'd1:    raw_sel = ry_r;
      default: raw_sel = rz_r;
    endcase
    case (cmd.sel)
      2'd0:    mg_sel = x_r;
      2'd1:    mg_sel = y_r;
      default: mg_sel = z_r;
    endcase
    prod    = PROD_W'(raw_sel) * $signed({1'b0, fr_r});
    prod_sh = prod >>> ato_pkg::SCALE_SHIFT;
    if (prod_sh > PROD_W'(8191)) begin
      mg_sat = 14'sd8191;
    end else if (prod_sh < -PROD_W'(8192)) begin
      mg_sat = -14'sd8192;
    end else begin
      mg_sat = prod_sh[ato_pkg::MG_W-1:0];
    end
    sq_full = mg_sel * mg_sel;
  end

  always_comb begin
    case (cmd.sel)
      2'd0:    sq_sum = {1'b0, sqy_r} + {1'b0, sqz_r};
      2'd1:    sq_sum = {1'b0, sqx_r} + {1'b0, sqz_r};
      default: sq_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
    endcase
    rem_sh = {rem_r, rad_r[ato_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, rt_r, 2'b01};
    ge     = (rem_sh >= trial);
    rt_nxt = {rt_r[ato_pkg::ROOT_W-2:0], ge};
  end

  always_comb begin
    case (cmd.sel)
      2'd0: begin
        vn = VW'(x_r) <<< 8;
        vd = VW'(y_r) <<< 8;
      end
      2'd1: begin
        vn = VW'(x_r) <<< 8;
        vd = $signed(VW'(ryz_r));
      end
      2'd2: begin
        vn = VW'(y_r) <<< 8;
        vd = $signed(VW'(rxz_r));
      end
      default: begin
        vn = $signed(VW'(rxy_r));
        vd = VW'(z_r) <<< 8;
      end
    endcase
    if (vd < 0) begin
      if (vn >= 0) begin
        n0 = -vd;
        d0 = vn;
        a0 = VW'(90 * 65536);
      end else begin
        n0 = vd;
        d0 = -vn;
        a0 = -VW'(90 * 65536);
      end
    end else begin
      n0 = vn;
      d0 = vd;
      a0 = '0;
    end
    nsh = num_r >>> cmd.step;
    dsh = den_r >>> cmd.step;
    tab = $signed(VW'(ato_pkg::atan_tab(cmd.step)));
  end

  always_comb begin
    mag = acc_r[VW-1] ? VW'(-acc_r) : VW'(acc_r);
    rnd = (mag + VW'(32768)) >> 16;
    deg = acc_r[VW-1] ? -$signed(rnd[DW-1:0]) : $signed(rnd[DW-1:0]);
    case (cmd.sel)
      2'd0: begin
        lo = -DW'(180);
        hi = DW'(180);
      end
      2'd3: begin
        lo = '0;
        hi = DW'(180);
      end
      default: begin
        lo = -DW'(90);
        hi = DW'(90);
      end
    endcase
    if (zero_r) begin
      deg_c = '0;
    end else if (deg < lo) begin
      deg_c = lo;
    end else if (deg > hi) begin
      deg_c = hi;
    end else begin
      deg_c = deg;
    end
  end

  always_comb begin
    cnt1  = tick_r ? cnt_r + 1'b1 : cnt_r;
    upd   = (cnt1 == per_r);
    abs_x = x_r[ato_pkg::MG_W-1] ? ato_pkg::MG_W'(-x_r) : ato_pkg::MG_W'(x_r);
    abs_y = y_r[ato_pkg::MG_W-1] ? ato_pkg::MG_W'(-y_r) : ato_pkg::MG_W'(y_r);
    abs_z = z_r[ato_pkg::MG_W-1] ? ato_pkg::MG_W'(-z_r) : ato_pkg::MG_W'(z_r);
    if (abs_y > abs_x) begin
      orient_nxt = y_r[ato_pkg::MG_W-1] ? ato_pkg::ORIENT_UP : ato_pkg::ORIENT_DOWN;
    end else if (abs_z > abs_x) begin
      orient_nxt = ato_pkg::ORIENT_UP;
    end else begin
      orient_nxt = x_r[ato_pkg::MG_W-1] ? ato_pkg::ORIENT_RIGHT : ato_pkg::ORIENT_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_r     <= ato_pkg::FULL_RANGE_RESET;
      per_r    <= ato_pkg::PERIOD_RESET;
      cnt_r    <= '0;
      orient_r <= ato_pkg::ORIENT_UP;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == ato_pkg::CFG_IDX_FULL_RANGE) begin
          fr_r <= cfg_ch.data[ato_pkg::FR_W-1:0];
        end else if (cfg_ch.index == ato_pkg::CFG_IDX_PERIOD) begin
          per_r <= cfg_ch.data[ato_pkg::PER_W-1:0];
        end
      end
      if (cmd.op == ato_pkg::OP_FINISH) begin
        ov_r  <= 1'b1;
        cnt_r <= upd ? '0 : cnt1;
        if (upd) begin
          orient_r <= orient_nxt;
        end
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ato_pkg::OP_LOAD: begin
        rx_r   <= raw_x;
        ry_r   <= raw_y;
        rz_r   <= raw_z;
        tick_r <= tick;
      end
      ato_pkg::OP_SCALE: begin
        case (cmd.sel)
          2'd0:    x_r <= mg_sat;
          2'd1:    y_r <= mg_sat;
          default: z_r <= mg_sat;
        endcase
      end
      ato_pkg::OP_SQUARE: begin
        case (cmd.sel)
          2'd0:    sqx_r <= sq_full[ato_pkg::SQ_W-1:0];
          2'd1:    sqy_r <= sq_full[ato_pkg::SQ_W-1:0];
          default: sqz_r <= sq_full[ato_pkg::SQ_W-1:0];
        endcase
      end
      ato_pkg::OP_ROOT_INIT: begin
        rad_r <= {sq_sum, 16'h0000};
        rem_r <= '0;
        rt_r  <= '0;
      end
      ato_pkg::OP_ROOT_STEP: begin
        rad_r <= rad_r << 2;
        rem_r <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        rt_r  <= rt_nxt;
        if (cmd.last) begin
          case (cmd.sel)
            2'd0:    ryz_r <= rt_nxt;
            2'd1:    rxz_r <= rt_nxt;
            default: rxy_r <= rt_nxt;
          endcase
        end
      end
      ato_pkg::OP_CORD_INIT: begin
        num_r  <= n0;
        den_r  <= d0;
        acc_r  <= a0;
        zero_r <= (vn == '0) && (vd == '0);
      end
      ato_pkg::OP_CORD_STEP: begin
        if (!num_r[VW-1]) begin
          den_r <= den_r + nsh;
          num_r <= num_r - dsh;
          acc_r <= acc_r + tab;
        end else begin
          den_r <= den_r - nsh;
          num_r <= num_r + dsh;
          acc_r <= acc_r - tab;
        end
      end
      ato_pkg::OP_CORD_STORE: begin
        case (cmd.sel)
          2'd0:    a2_r <= deg_c;
          2'd1:    ax_r <= deg_c;
          2'd2:    ay_r <= deg_c;
          default: az_r <= deg_c;
        endcase
      end
      ato_pkg::OP_FINISH: begin
        out_ch.x_mg        <= x_r;
        out_ch.y_mg        <= y_r;
        out_ch.z_mg        <= z_r;
        out_ch.tilt_2d     <= a2_r[8:0];
        out_ch.angle_x     <= ax_r[7:0];
        out_ch.angle_y     <= ay_r[7:0];
        out_ch.angle_z     <= az_r[7:0];
        out_ch.orientation <= upd ? orient_nxt : orient_r;
        out_ch.led_onehot  <= ato_pkg::led_code(upd ? orient_nxt : orient_r);
        out_ch.update      <= upd;
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = ov_r;

endmodule
